// ===== src/ifd_pkg.sv =====
// Package with shared constants and types for the information frame deframer.
package ifd_pkg;

   localparam int MAX_FRAME_BYTES = 1024;
   localparam int RAW_W = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] STUFF_XOR = 8'h20;
   localparam int MIN_FRAME = 7;

   localparam logic [7:0] ADDR_RESET = 8'h03;

   localparam logic [7:0] CSR_ADDRESS_BYTE = 8'd0;
   localparam logic [7:0] CSR_INITIAL_SEQUENCE = 8'd1;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_OK = 3'd1,
      KIND_BCC2 = 3'd2,
      KIND_SHORT = 3'd3,
      KIND_EDGE = 3'd4,
      KIND_BCC1 = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data_byte;
      logic seq_bit;
      logic duplicate;
   } result_type;

endpackage

// ===== src/info_frame_deframer.sv =====
// Information frame deframer: header hunt, byte destuffing, BCC checks and status beats.
// Next-state and result logic is one pass, registered in the output or skid stage.
// Throughput: one received byte per cycle while req_stall is low.
// A two-entry output register and skid stage keep req_ accepting while one result waits.
// Reset is synchronous, active high; it returns to the flag hunt and loads default registers.
module info_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_seq_bit,
   output logic       rsp_duplicate,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_FLAG,
      ST_ADDR,
      ST_CTRL,
      ST_BODY
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] address_ff, address_in;
   logic init_seq_ff, init_seq_in;
   logic frame_seq_ff, frame_seq_in;
   logic expected_seq_ff, expected_seq_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic held_valid_ff, held_valid_in;
   logic escape_ff, escape_in;
   logic [7:0] xor_ff, xor_in;
   logic [ifd_pkg::RAW_W-1:0] count_ff, count_in;

   ifd_pkg::result_type out_ff, out_in, skid_ff, skid_in, res;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic res_valid, accept, take;
   logic [7:0] b, v;

   assign accept = req_valid && !req_stall;
   assign take = out_valid_ff && !rsp_stall;
   assign b = req_rx_byte;
   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;

   always_comb begin
      state_in = state_ff;
      address_in = address_ff;
      init_seq_in = init_seq_ff;
      frame_seq_in = frame_seq_ff;
      expected_seq_in = expected_seq_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      escape_in = escape_ff;
      xor_in = xor_ff;
      count_in = count_ff;
      res_valid = 1'b0;
      res.kind = ifd_pkg::KIND_PAYLOAD;
      res.data_byte = 8'h00;
      res.seq_bit = frame_seq_ff;
      res.duplicate = 1'b0;
      v = b;
      if (accept) begin
         case (state_ff)
            ST_HUNT: begin
               if (b == ifd_pkg::FLAG_BYTE) begin
                  state_in = ST_FLAG;
                  count_in = ifd_pkg::RAW_W'(1);
               end
            end
            ST_FLAG: begin
               if (b == address_ff) begin
                  state_in = ST_ADDR;
                  count_in = ifd_pkg::RAW_W'(2);
               end else if (b == ifd_pkg::FLAG_BYTE) begin
                  count_in = ifd_pkg::RAW_W'(1);
               end else begin
                  state_in = ST_HUNT;
               end
            end
            ST_ADDR: begin
               if (b == ifd_pkg::FLAG_BYTE) begin
                  state_in = ST_FLAG;
                  count_in = ifd_pkg::RAW_W'(1);
               end else begin
                  frame_seq_in = b[5];
                  state_in = ST_CTRL;
                  count_in = ifd_pkg::RAW_W'(3);
               end
            end
            ST_CTRL: begin
               if (b == (address_ff ^ {2'b00, frame_seq_ff, 5'b00000})) begin
                  state_in = ST_BODY;
                  count_in = ifd_pkg::RAW_W'(4);
                  held_byte_in = 8'h00;
                  held_valid_in = 1'b0;
                  escape_in = 1'b0;
                  xor_in = 8'h00;
               end else begin
                  state_in = (b == ifd_pkg::FLAG_BYTE) ? ST_FLAG : ST_HUNT;
                  if (b == ifd_pkg::FLAG_BYTE) begin
                     count_in = ifd_pkg::RAW_W'(1);
                  end
                  res_valid = 1'b1;
                  res.kind = ifd_pkg::KIND_BCC1;
               end
            end
            ST_BODY: begin
               if (b == ifd_pkg::FLAG_BYTE) begin
                  state_in = ST_HUNT;
                  res_valid = 1'b1;
                  res.duplicate = (frame_seq_ff == expected_seq_ff);
                  if (count_ff < ifd_pkg::RAW_W'(ifd_pkg::MIN_FRAME - 1) || !held_valid_ff) begin
                     res.kind = ifd_pkg::KIND_SHORT;
                  end else if (escape_ff) begin
                     res.kind = ifd_pkg::KIND_EDGE;
                  end else if (held_byte_ff != xor_ff) begin
                     res.kind = ifd_pkg::KIND_BCC2;
                  end else begin
                     res.kind = ifd_pkg::KIND_OK;
                     expected_seq_in = !expected_seq_ff;
                  end
               end else if (count_ff >= ifd_pkg::RAW_W'(ifd_pkg::MAX_FRAME_BYTES - 1)) begin
                  state_in = ST_HUNT;
                  res_valid = 1'b1;
                  res.kind = ifd_pkg::KIND_EDGE;
                  res.duplicate = (frame_seq_ff == expected_seq_ff);
               end else begin
                  count_in = count_ff + ifd_pkg::RAW_W'(1);
                  if (!escape_ff && b == ifd_pkg::ESC_BYTE) begin
                     escape_in = 1'b1;
                  end else begin
                     escape_in = 1'b0;
                     v = escape_ff ? (b ^ ifd_pkg::STUFF_XOR) : b;
                     held_byte_in = v;
                     held_valid_in = 1'b1;
                     if (held_valid_ff) begin
                        xor_in = xor_ff ^ held_byte_ff;
                        res_valid = 1'b1;
                        res.kind = ifd_pkg::KIND_PAYLOAD;
                        res.data_byte = held_byte_ff;
                     end
                  end
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
      if (csr_valid && csr_ready) begin
         if (csr_index == ifd_pkg::CSR_ADDRESS_BYTE) begin
            address_in = csr_wdata;
         end else if (csr_index == ifd_pkg::CSR_INITIAL_SEQUENCE) begin
            init_seq_in = csr_wdata[0];
            expected_seq_in = csr_wdata[0];
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         address_ff <= ifd_pkg::ADDR_RESET;
         init_seq_ff <= 1'b0;
         frame_seq_ff <= 1'b0;
         expected_seq_ff <= 1'b0;
         held_byte_ff <= 8'h00;
         held_valid_ff <= 1'b0;
         escape_ff <= 1'b0;
         xor_ff <= 8'h00;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         address_ff <= address_in;
         init_seq_ff <= init_seq_in;
         frame_seq_ff <= frame_seq_in;
         expected_seq_ff <= expected_seq_in;
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         escape_ff <= escape_in;
         xor_ff <= xor_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_data_byte = out_ff.data_byte;
   assign rsp_seq_bit = out_ff.seq_bit;
   assign rsp_duplicate = out_ff.duplicate;

endmodule
